[rtl/sdiv_pkg.sv]
// ----------------------------------------------------------------------------
// sdiv_pkg
// Shared types and constants of the signed divider with modes.
// ----------------------------------------------------------------------------
`default_nettype none
package sdiv_pkg;

    localparam int unsigned DataWidth = 64;
    localparam int unsigned CntWidth  = 6;
    localparam int unsigned QueueDepth = 2;

    localparam logic [1:0] ModeW32  = 2'd0;
    localparam logic [1:0] ModeW64  = 2'd2;

    localparam logic [63:0] QuotZeroPos32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] QuotZeroNeg32 = 64'hFFFF_FFFF_0000_0001;
    localparam logic [63:0] QuotZeroPos64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] QuotZeroNeg64 = 64'h0000_0000_0000_0001;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_FIX,
        ST_DONE
    } div_state_t;

    // classified job handed from front to back
    typedef struct packed {
        logic        zero_div;
        logic        flag;
        logic        mode32;
        logic        n_neg;
        logic        q_neg;
        logic [63:0] n_ext;
        logic [63:0] n_mag;
        logic [63:0] d_mag;
    } div_job_t;

endpackage
`default_nettype wire

[rtl/sdiv_front.sv]
// ----------------------------------------------------------------------------
// sdiv_front
// Accepts requests, sign-extends operands, takes magnitudes, flags zero.
// ----------------------------------------------------------------------------
`default_nettype none
module sdiv_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic signed [63:0] numerator,
    input  wire logic signed [63:0] denominator,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output sdiv_pkg::div_job_t      job
);

    logic                 job_valid_reg;
    logic                 job_valid_next;
    sdiv_pkg::div_job_t   job_reg;
    sdiv_pkg::div_job_t   job_next;
    logic [63:0]          n_ext;
    logic [63:0]          d_ext;

    assign in_ready  = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        if (mode == sdiv_pkg::ModeW32)
        begin
            n_ext = {{32{numerator[31]}}, numerator[31:0]};
        end
        else
        begin
            n_ext = numerator;
        end
        if (mode == sdiv_pkg::ModeW64)
        begin
            d_ext = denominator;
        end
        else
        begin
            d_ext = {{32{denominator[31]}}, denominator[31:0]};
        end
        job_next.zero_div = (d_ext == 64'd0);
        job_next.flag     = (denominator == 64'sd0);
        job_next.mode32   = (mode == sdiv_pkg::ModeW32);
        job_next.n_neg    = n_ext[63];
        job_next.q_neg    = n_ext[63] ^ d_ext[63];
        job_next.n_ext    = n_ext;
        job_next.n_mag    = n_ext[63] ? (64'd0 - n_ext) : n_ext;
        job_next.d_mag    = d_ext[63] ? (64'd0 - d_ext) : d_ext;
        job_valid_next    = job_valid_reg;
        if (in_ready)
        begin
            job_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule
`default_nettype wire

[rtl/sdiv_queue.sv]
// ----------------------------------------------------------------------------
// sdiv_queue
// Two-entry queue that decouples the front stage from the divide engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sdiv_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_valid,
    output logic                    wr_ready,
    input  wire sdiv_pkg::div_job_t wr_data,
    output logic                    rd_valid,
    input  wire logic               rd_ready,
    output sdiv_pkg::div_job_t      rd_data
);

    sdiv_pkg::div_job_t mem [sdiv_pkg::QueueDepth];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("push lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("pop lost");

endmodule
`default_nettype wire

[rtl/sdiv_engine.sv]
// ----------------------------------------------------------------------------
// sdiv_engine
// Radix-2 restoring divider on magnitudes, sign fix-up and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sdiv_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire sdiv_pkg::div_job_t job,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      quotient,
    output logic signed [63:0]      remainder,
    output logic                    div_by_zero
);

    sdiv_pkg::div_state_t state_reg;
    sdiv_pkg::div_state_t state_next;
    logic [5:0]   cnt_reg;
    logic [5:0]   cnt_next;
    logic [63:0]  q_reg;
    logic [63:0]  r_reg;
    logic [63:0]  d_reg;
    logic         q_neg_reg;
    logic         n_neg_reg;
    logic [63:0]  quot_reg;
    logic [63:0]  rem_reg;
    logic         flag_reg;
    logic [64:0]  r_shift;
    logic [64:0]  r_diff;
    logic         load;
    logic         special;

    assign load    = job_valid && job_ready;
    assign special = job.zero_div;
    assign r_shift = {r_reg, q_reg[63]};
    assign r_diff  = r_shift - {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            sdiv_pkg::ST_IDLE:
            begin
                if (load)
                begin
                    state_next = special ? sdiv_pkg::ST_DONE : sdiv_pkg::ST_ITER;
                    cnt_next   = '1;
                end
            end
            sdiv_pkg::ST_ITER:
            begin
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = sdiv_pkg::ST_FIX;
                end
            end
            sdiv_pkg::ST_FIX:
            begin
                state_next = sdiv_pkg::ST_DONE;
            end
            sdiv_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = sdiv_pkg::ST_IDLE;
                    if (load)
                    begin
                        state_next = special ? sdiv_pkg::ST_DONE : sdiv_pkg::ST_ITER;
                        cnt_next   = '1;
                    end
                end
            end
            default:
            begin
                state_next = sdiv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ready = (state_reg == sdiv_pkg::ST_IDLE)
                 || ((state_reg == sdiv_pkg::ST_DONE) && out_ready);
        out_valid   = (state_reg == sdiv_pkg::ST_DONE);
        quotient    = quot_reg;
        remainder   = rem_reg;
        div_by_zero = flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdiv_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg     <= job.n_mag;
            r_reg     <= '0;
            d_reg     <= job.d_mag;
            q_neg_reg <= job.q_neg;
            n_neg_reg <= job.n_neg;
            flag_reg  <= job.flag;
            if (special)
            begin
                rem_reg <= job.n_ext;
                if (job.mode32)
                begin
                    quot_reg <= job.n_neg ? sdiv_pkg::QuotZeroNeg32
                                          : sdiv_pkg::QuotZeroPos32;
                end
                else
                begin
                    quot_reg <= job.n_neg ? sdiv_pkg::QuotZeroNeg64
                                          : sdiv_pkg::QuotZeroPos64;
                end
            end
        end
        else if (state_reg == sdiv_pkg::ST_ITER)
        begin
            if (!r_diff[64])
            begin
                r_reg <= r_diff[63:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift[63:0];
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
        else if (state_reg == sdiv_pkg::ST_FIX)
        begin
            quot_reg <= q_neg_reg ? (64'd0 - q_reg) : q_reg;
            rem_reg  <= n_neg_reg ? (64'd0 - r_reg) : r_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdiv_pkg::ST_ITER && cnt_reg == 6'd0) |=>
        (state_reg == sdiv_pkg::ST_FIX))
        else $error("iteration did not end in fix-up");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdiv_pkg::ST_FIX) |=> out_valid)
        else $error("fix-up not followed by result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(quot_reg)))
        else $error("result dropped under stall");

endmodule
`default_nettype wire

[rtl/signed_divider_with_modes_core.sv]
// ----------------------------------------------------------------------------
// signed_divider_with_modes_core
// Signed divider, 32/32, 64/32 and 64/64 modes, with divide-by-zero flag.
//
//   channel | signals                                 | role
//   in      | in_valid in_ready mode numerator        | request beat
//           | denominator                             |
//   out     | out_valid out_ready quotient remainder  | result beat
//           | div_by_zero                             |
//
// A division holds the engine for 64 radix-2 steps, a fix-up step and the result
// state; the next job loads in the result state. The shift-subtract loop gives
// one quotient bit per cycle; a zero divisor goes straight to the result state.
// A request passes the front register and the queue. The front stage and a two-entry
// queue take new beats while the engine works. No clearing pass after reset.
// Stalls on out hold the result.
// ----------------------------------------------------------------------------
`default_nettype none
module signed_divider_with_modes_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         mode,
    input  wire logic signed [63:0] numerator,
    input  wire logic signed [63:0] denominator,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      quotient,
    output logic signed [63:0]      remainder,
    output logic                    div_by_zero
);

    logic               f_valid;
    logic               f_ready;
    sdiv_pkg::div_job_t f_job;
    logic               q_valid;
    logic               q_ready;
    sdiv_pkg::div_job_t q_job;

    sdiv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .numerator   (numerator),
        .denominator (denominator),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    sdiv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_job)
    );

    sdiv_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .job         (q_job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .quotient    (quotient),
        .remainder   (remainder),
        .div_by_zero (div_by_zero)
    );

endmodule
`default_nettype wire

[dv/signed_divider_with_modes_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_divider_with_modes_core_test
// Checks quotient, remainder and zero flag of every division beat against a
// table value or a local predictor; a directed table of corner cases, then random
// traffic with bursts of idle cycles on both channels, ending in a calm stretch.
// ----------------------------------------------------------------------------
module signed_divider_with_modes_core_test;

    localparam logic [1:0] ModeW64x32  = 2'd1;
    localparam logic [1:0] ModeW64x32b = 2'd3;
    localparam logic [63:0] Min64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] Max64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int RandBeats = 500;
    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic [63:0] quo;
        logic [63:0] rem;
        logic        dz;
    } div_res_t;

    typedef struct {
        logic [1:0]  md;
        logic [63:0] num;
        logic [63:0] den;
        logic        known;
        div_res_t    res;
    } div_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic signed [63:0] numerator = '0;
    logic signed [63:0] denominator = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [63:0] quotient;
    logic signed [63:0] remainder;
    logic div_by_zero;

    div_res_t pending_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit calm = 0;
    bit drain_done = 0;

    signed_divider_with_modes_core dut (.*);

    always #1 clk = ~clk;

    function automatic logic [63:0] sext32(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic div_res_t divide(logic [1:0] md, logic [63:0] num,
                                        logic [63:0] den);
        div_res_t r;
        logic [63:0] n, d, nm, dm, qm, rm;
        n = (md == sdiv_pkg::ModeW32) ? sext32(num) : num;
        d = (md == sdiv_pkg::ModeW64) ? den : sext32(den);
        r.dz = (den == 64'd0);
        if (d == 64'd0)
        begin
            r.rem = n;
            if (md == sdiv_pkg::ModeW32)
            begin
                r.quo = n[63] ? sdiv_pkg::QuotZeroNeg32 : sdiv_pkg::QuotZeroPos32;
            end
            else
            begin
                r.quo = n[63] ? sdiv_pkg::QuotZeroNeg64 : sdiv_pkg::QuotZeroPos64;
            end
        end
        else
        begin
            nm = n[63] ? -n : n;
            dm = d[63] ? -d : d;
            qm = nm / dm;
            rm = nm % dm;
            r.quo = (n[63] != d[63]) ? -qm : qm;
            r.rem = n[63] ? -rm : rm;
        end
        return r;
    endfunction

    // hold valid after the beat; the next call or the caller drops it
    task automatic send(logic [1:0] md, logic [63:0] num, logic [63:0] den,
                        div_res_t res);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        pending_q.push_back(res);
        in_valid <= 1'b1;
        mode <= md;
        numerator <= num;
        denominator <= den;
        do @(posedge clk); while (!in_ready);
    endtask

    // sink side: random stall bursts
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 8);
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        div_res_t e, got;
        if (out_valid && out_ready)
        begin
            got = '{quotient, remainder, div_by_zero};
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end
            else
            begin
                e = pending_q.pop_front();
                if (got !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp q=%h r=%h z=%b got q=%h r=%h z=%b",
                                 e.quo, e.rem, e.dz, quotient, remainder, div_by_zero);
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IdleLimit && !drain_done)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        div_row_t rows[$];
        logic [1:0] md;
        logic [63:0] num, den;
        int pick;
        rows = '{
            '{sdiv_pkg::ModeW32, 64'd7, 64'd0, 1'b1,
              '{sdiv_pkg::QuotZeroPos32, 64'd7, 1'b1}},
            '{sdiv_pkg::ModeW32, 64'hFFFF_FFFF, 64'd0, 1'b1,
              '{sdiv_pkg::QuotZeroNeg32, AllOnes, 1'b1}},
            '{sdiv_pkg::ModeW32, 64'h8000_0000, AllOnes, 1'b1,
              '{64'h0000_0000_8000_0000, 64'd0, 1'b0}},
            '{sdiv_pkg::ModeW32, 64'd5, 64'h1_0000_0000, 1'b1,
              '{sdiv_pkg::QuotZeroPos32, 64'd5, 1'b0}},
            '{ModeW64x32, Min64, AllOnes, 1'b1, '{Min64, 64'd0, 1'b0}},
            '{ModeW64x32b, 64'd9, 64'h5_0000_0000, 1'b1,
              '{sdiv_pkg::QuotZeroPos64, 64'd9, 1'b0}},
            '{sdiv_pkg::ModeW64, Min64, AllOnes, 1'b1, '{Min64, 64'd0, 1'b0}},
            '{sdiv_pkg::ModeW64, AllOnes, 64'd0, 1'b1,
              '{sdiv_pkg::QuotZeroNeg64, AllOnes, 1'b1}},
            '{sdiv_pkg::ModeW64, Max64, 64'd0, 1'b1,
              '{sdiv_pkg::QuotZeroPos64, Max64, 1'b1}},
            '{sdiv_pkg::ModeW64, Max64, Max64, 1'b0, '0},
            '{sdiv_pkg::ModeW64, Max64, Min64, 1'b0, '0},
            '{sdiv_pkg::ModeW64, Min64, 64'd3, 1'b0, '0},
            '{sdiv_pkg::ModeW64, -64'sd7, 64'd2, 1'b0, '0},
            '{ModeW64x32, Max64, 64'h7FFF_FFFF, 1'b0, '0},
            '{ModeW64x32b, -64'sd100, 64'hFFFF_FFFF_8000_0000, 1'b0, '0},
            '{sdiv_pkg::ModeW32, 64'h1234_5678_7FFF_FFFF, 64'hABCD_0000_FFFF_FFFD,
              1'b0, '0},
            '{sdiv_pkg::ModeW32, 64'd0, 64'd1, 1'b0, '0},
            '{ModeW64x32, 64'd0, AllOnes, 1'b0, '0}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send(rows[i].md, rows[i].num, rows[i].den,
                 rows[i].known ? rows[i].res
                               : divide(rows[i].md, rows[i].num, rows[i].den));
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        for (int i = 0; i < RandBeats; i++)
        begin
            if (i == RandBeats - 60)
            begin
                in_valid <= 1'b0;
                wait (pending_q.size() == 0);
                calm = 1;
            end
            md = 2'($urandom_range(0, 3));
            num = {$urandom, $urandom};
            den = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (pick == 0)
                den = (md == sdiv_pkg::ModeW64) ? 64'd0
                                                : {den[63:32] & {32{den[0]}}, 32'd0};
            else if (pick == 1) den = den >> $urandom_range(0, 63);
            else if (pick == 2) num = num >> $urandom_range(0, 63);
            else if (pick == 3)
            begin
                num = $urandom_range(0, 1) ? Min64 : {$urandom, 32'h8000_0000};
                den = AllOnes;
            end
            else if (pick == 4) den = {{40{den[23]}}, den[23:0]};
            send(md, num, den, divide(md, num, den));
        end
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (200) @(posedge clk);
        drain_done = 1;
        if (mismatches == 0 && pending_q.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
